FILE: hdl/hbd_pkg.sv
package hbd_pkg;

	// Sizing of the code tree store and the pending right-slot stack
	localparam int MAX_NODES = 512;
	localparam int MAX_DEPTH = 256;

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int NCNT_W = $clog2(MAX_NODES + 1);
	localparam int SCNT_W = $clog2(MAX_DEPTH + 1);
	// top of stack lives in a register, the rest in memory
	localparam int STK_DEPTH = MAX_DEPTH - 1;
	localparam int STK_AW = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;

	localparam int SYM_W = 8;
	localparam int CFG_AW = 1;
	localparam int CFG_DW = 8;

	localparam logic [SYM_W-1:0] INTERNAL_MARKER_RST = 8'd42;
	localparam logic [SYM_W-1:0] END_MARKER_RST = 8'd0;

	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_KEY   = 2'd1,
		FUNC_BIT   = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		KIND_SYMBOL   = 2'd0,
		KIND_END      = 2'd1,
		KIND_INVALID  = 2'd2,
		KIND_TREE_ERR = 2'd3
	} kind_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_INTERNAL_MARKER = 1'd0,
		REG_END_MARKER      = 1'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]       func;
		logic [SYM_W-1:0] key_symbol;
		logic             code_bit;
	} in_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic [1:0]       kind;
	} out_item_t;

	// What a parent keeps about one of its children
	typedef struct packed {
		logic [NODE_W-1:0] idx;
		logic              internal;
		logic [SYM_W-1:0]  sym;
	} child_rec_t;

	typedef struct packed {
		logic              clear;
		logic              pop;
		logic              push;
		logic [NODE_W-1:0] idx;
	} stk_cmd_t;

	typedef struct packed {
		logic              left_en;
		logic [NODE_W-1:0] left_addr;
		logic              right_en;
		logic [NODE_W-1:0] right_addr;
		child_rec_t        rec;
	} nm_wr_t;

endpackage

FILE: hdl/huffman_tree_load_and_bit_decode.sv
// Channel | Signals                            | Accepted when
// in      | in_valid, in_ready, in_data        | in_valid && in_ready
// out     | out_valid, out_ready, out_data     | out_valid && out_ready
// cfg     | cfg_we, cfg_addr, cfg_wdata        | cfg_we
//
// One request per cycle while the result slot is not stalled; a request passes the
// input register, then the result register, before its result shows.
// For a code bit, the node record of the next internal node is read from the
// node memory at the edge that takes the bit, ready for the next bit.
// Reset (arst_n low) clears control state only; memories need no clearing pass.
// A stalled result holds the result register and, one request later, the input.
module huffman_tree_load_and_bit_decode (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  hbd_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output hbd_pkg::out_item_t         out_data,
	input  logic                       cfg_we,
	input  logic [hbd_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [hbd_pkg::CFG_DW-1:0] cfg_wdata
);
	import hbd_pkg::*;

	in_item_t          in_s1;
	logic              in_v_s1;
	out_item_t         out_q;
	logic              out_v_q;
	logic              go;

	logic [SYM_W-1:0]  imark_q;
	logic [SYM_W-1:0]  emark_q;
	logic [NCNT_W-1:0] nodes_q;
	logic              prev_int_q;
	logic              complete_q;
	logic              stopped_q;
	logic              at_root_q;
	logic              root_int_q;

	logic [NCNT_W-1:0] nodes_d;
	logic              prev_int_d;
	logic              complete_d;
	logic              stopped_d;
	logic              at_root_d;
	logic              root_int_d;

	stk_cmd_t          stk_cmd;
	logic [NODE_W-1:0] stk_top;
	logic [SCNT_W-1:0] stk_count;
	nm_wr_t            nm_wr;
	logic              rd_en;
	child_rec_t        cur_left;
	child_rec_t        cur_right;
	child_rec_t        child;

	logic              is_int;
	logic              need_pop;
	logic [SCNT_W-1:0] cnt_after;
	logic              load_err;
	logic              res_v;
	out_item_t         res;

	hbd_stack u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (stk_cmd),
		.top   (stk_top),
		.count (stk_count)
	);

	hbd_node_mem u_node_mem (
		.clk      (clk),
		.wr       (nm_wr),
		.rd_en    (rd_en),
		.rd_addr  (child.idx),
		.at_root  (at_root_q),
		.cur_left (cur_left),
		.cur_right(cur_right)
	);

	// Handshake: the request in s1 moves on when the result slot is free
	assign go = in_v_s1 && (!out_v_q || out_ready);
	assign in_ready = !in_v_s1 || go;
	assign out_valid = out_v_q;
	assign out_data = out_q;

	// Tree load checks
	always_comb begin
		is_int = (in_s1.key_symbol == imark_q);
		need_pop = (nodes_q != '0) && !prev_int_q;
		cnt_after = stk_count - SCNT_W'(need_pop);
		load_err = (nodes_q == NCNT_W'(MAX_NODES)) || (need_pop && (stk_count == '0)) ||
			(is_int && (cnt_after == SCNT_W'(MAX_DEPTH)));
		child = in_s1.code_bit ? cur_right : cur_left;
	end

	// Request processing
	always_comb begin
		res_v = 1'b0;
		res.symbol = '0;
		res.kind = KIND_SYMBOL;
		stk_cmd = '0;
		stk_cmd.idx = NODE_W'(nodes_q);
		nm_wr.left_en = 1'b0;
		nm_wr.left_addr = NODE_W'(nodes_q - NCNT_W'(1));
		nm_wr.right_en = 1'b0;
		nm_wr.right_addr = stk_top;
		nm_wr.rec.idx = NODE_W'(nodes_q);
		nm_wr.rec.internal = is_int;
		nm_wr.rec.sym = in_s1.key_symbol;
		rd_en = 1'b0;
		nodes_d = nodes_q;
		prev_int_d = prev_int_q;
		complete_d = complete_q;
		stopped_d = stopped_q;
		at_root_d = at_root_q;
		root_int_d = root_int_q;
		if (go) begin
			case (in_s1.func)
				FUNC_START: begin
					stk_cmd.clear = 1'b1;
					nodes_d = '0;
					complete_d = 1'b0;
					stopped_d = 1'b0;
					at_root_d = 1'b1;
				end
				FUNC_KEY: begin
					if (!stopped_q && !complete_q) begin
						if (load_err) begin
							res_v = 1'b1;
							res.kind = KIND_TREE_ERR;
							stopped_d = 1'b1;
						end else begin
							// attach to the open slot, then place the node
							nm_wr.left_en = (nodes_q != '0) && prev_int_q;
							nm_wr.right_en = need_pop;
							stk_cmd.pop = need_pop;
							stk_cmd.push = is_int;
							nodes_d = nodes_q + NCNT_W'(1);
							prev_int_d = is_int;
							if (nodes_q == '0) begin
								root_int_d = is_int;
							end
							if (!is_int && (cnt_after == '0)) begin
								complete_d = 1'b1;
								at_root_d = 1'b1;
							end
						end
					end
				end
				FUNC_BIT: begin
					if (!stopped_q) begin
						if (!complete_q) begin
							res_v = 1'b1;
							res.kind = KIND_TREE_ERR;
							stopped_d = 1'b1;
						end else if (at_root_q && !root_int_q) begin
							// single-leaf tree: root has no children
							res_v = 1'b1;
							res.kind = KIND_INVALID;
							stopped_d = 1'b1;
						end else if (child.internal) begin
							at_root_d = 1'b0;
							rd_en = 1'b1;
						end else begin
							res_v = 1'b1;
							res.symbol = child.sym;
							at_root_d = 1'b1;
							if (child.sym == emark_q) begin
								res.kind = KIND_END;
								stopped_d = 1'b1;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			in_v_s1 <= 1'b1;
		end else if (go) begin
			in_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (go && res_v) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res_v) begin
			out_q <= res;
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q <= '0;
			prev_int_q <= 1'b0;
			complete_q <= 1'b0;
			stopped_q <= 1'b0;
			at_root_q <= 1'b1;
			root_int_q <= 1'b0;
		end else begin
			nodes_q <= nodes_d;
			prev_int_q <= prev_int_d;
			complete_q <= complete_d;
			stopped_q <= stopped_d;
			at_root_q <= at_root_d;
			root_int_q <= root_int_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imark_q <= INTERNAL_MARKER_RST;
			emark_q <= END_MARKER_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_INTERNAL_MARKER: imark_q <= cfg_wdata;
				REG_END_MARKER:      emark_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: hdl/hbd_stack.sv
module hbd_stack (
	input  logic                     clk,
	input  logic                     arst_n,
	input  hbd_pkg::stk_cmd_t        cmd,
	output logic [hbd_pkg::NODE_W-1:0] top,
	output logic [hbd_pkg::SCNT_W-1:0] count
);
	import hbd_pkg::*;

	logic [NODE_W-1:0] mem [STK_DEPTH];
	logic [NODE_W-1:0] top_q;
	logic [NODE_W-1:0] rd_q;    // holds entry count_q-2 whenever count_q is at least 2
	logic [SCNT_W-1:0] count_q;
	logic [SCNT_W-1:0] cnt_pop;
	logic [SCNT_W-1:0] cnt_nxt;
	logic              we;
	logic [STK_AW-1:0] wa;
	logic [STK_AW-1:0] ra;

	// Next count and memory addresses
	always_comb begin
		cnt_pop = count_q - SCNT_W'(cmd.pop);
		cnt_nxt = cmd.clear ? '0 : cnt_pop + SCNT_W'(cmd.push);
		// push+pop leaves the memory as it is; push alone spills the old top
		we = cmd.push && !cmd.pop && !cmd.clear && (count_q != '0);
		wa = STK_AW'(count_q - SCNT_W'(1));
		ra = (cnt_nxt >= SCNT_W'(2)) ? STK_AW'(cnt_nxt - SCNT_W'(2)) : '0;
	end

	// Spill memory, next-below-top prefetch with write forwarding
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= top_q;
		end
		rd_q <= (we && (wa == ra)) ? top_q : mem[ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q <= cmd.idx;
		end else if (cmd.pop) begin
			top_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= cnt_nxt;
		end
	end

	assign top = top_q;
	assign count = count_q;

endmodule

FILE: hdl/hbd_node_mem.sv
module hbd_node_mem (
	input  logic                       clk,
	input  hbd_pkg::nm_wr_t            wr,
	input  logic                       rd_en,
	input  logic [hbd_pkg::NODE_W-1:0] rd_addr,
	input  logic                       at_root,
	output hbd_pkg::child_rec_t        cur_left,
	output hbd_pkg::child_rec_t        cur_right
);
	import hbd_pkg::*;

	// Per node: what its left and right children are
	child_rec_t left_mem [MAX_NODES];
	child_rec_t right_mem [MAX_NODES];
	child_rec_t rd_left_q;
	child_rec_t rd_right_q;
	child_rec_t root_left_q;
	child_rec_t root_right_q;

	always_ff @(posedge clk) begin
		if (wr.left_en) begin
			left_mem[wr.left_addr] <= wr.rec;
		end
		if (wr.right_en) begin
			right_mem[wr.right_addr] <= wr.rec;
		end
		if (rd_en) begin
			rd_left_q <= left_mem[rd_addr];
			rd_right_q <= right_mem[rd_addr];
		end
	end

	// Root copy, so a walk can restart without a memory read
	always_ff @(posedge clk) begin
		if (wr.left_en && (wr.left_addr == '0)) begin
			root_left_q <= wr.rec;
		end
		if (wr.right_en && (wr.right_addr == '0)) begin
			root_right_q <= wr.rec;
		end
	end

	assign cur_left = at_root ? root_left_q : rd_left_q;
	assign cur_right = at_root ? root_right_q : rd_right_q;

endmodule

FILE: hdl/hbd_checker.sv
module hbd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input hbd_pkg::out_item_t         out_data
);
	import hbd_pkg::*;

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Errors carry no symbol
	a_err_sym: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind == KIND_INVALID || out_data.kind == KIND_TREE_ERR)
		|-> out_data.symbol == '0)
		else $error("error result with nonzero symbol");

	// With the result slot empty the input side never stalls
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result slot");

	// A fresh result follows a request that passed the input register, then the result register
	a_res_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching request");

endmodule

bind huffman_tree_load_and_bit_decode hbd_checker u_hbd_checker (.*);
